@@ src/aabb_pkg.sv @@
// shared types, widths and face codes for the box overlap block
`timescale 1ns / 1ps
`default_nettype none
package aabb_pkg;

  localparam int COORD_W = 32;
  localparam int LEN_W   = 31;
  localparam int BOUND_W = 36;
  localparam int DEPTH_W = 36;
  localparam int FACE_W  = 3;
  localparam int AXES    = 3;
  localparam int FACES   = 2 * AXES;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  typedef logic signed [BOUND_W-1:0] bound_t;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic signed [COORD_W-1:0] off_z;
    logic        [LEN_W-1:0]   len_x;
    logic        [LEN_W-1:0]   len_y;
    logic        [LEN_W-1:0]   len_z;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [FACE_W-1:0]  face;
    logic [DEPTH_W-1:0] depth;
  } result_t;

  typedef struct packed {
    bound_t lo;
    bound_t hi;
  } span_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
  } test_ctl_t;

endpackage
`default_nettype wire

@@ src/aabb_overlap_min_penetration.sv @@
// top level: box overlap test with minimum-penetration face
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_stall      item_t   (load or test box)
//   result   out        result_valid / result_stall  result_t (hit, face, depth)
//
// one transaction per cycle unless a stalled result holds the pipe; a test result passes through every stage below
// pipeline: input reg, bounds reg, face depth reg, pair min reg, result reg
// load transactions update the reference box and produce no result
// reset clears the reference box to a point at the origin and empties the pipe
// a stalled result freezes the whole pipe, so item_stall follows result_stall
`timescale 1ns / 1ps
`default_nettype none
module aabb_overlap_min_penetration import aabb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic                       advance;
  logic                       s1_valid;
  item_t                      s1_item;
  span_t  [AXES-1:0]          span_next;
  logic                       s2_valid;
  logic                       s2_command;
  span_t  [AXES-1:0]          s2_span;
  span_t  [AXES-1:0]          ref_span;
  logic   [AXES-1:0]          overlap;
  bound_t [FACES-1:0]         faces_next;
  bound_t [FACES-1:0]         faces;
  test_ctl_t                  ctl_next;
  test_ctl_t                  ctl;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= item;
    end
  end

  aabb_bounds u_bounds_x (
    .pos  (s1_item.pos_x),
    .off  (s1_item.off_x),
    .len  (s1_item.len_x),
    .span (span_next[0])
  );

  aabb_bounds u_bounds_y (
    .pos  (s1_item.pos_y),
    .off  (s1_item.off_y),
    .len  (s1_item.len_y),
    .span (span_next[1])
  );

  aabb_bounds u_bounds_z (
    .pos  (s1_item.pos_z),
    .off  (s1_item.off_z),
    .len  (s1_item.len_z),
    .span (span_next[2])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_command <= s1_item.command;
      s2_span    <= span_next;
    end
  end

  // reference box
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_span <= '0;
    end else if (advance && s2_valid && s2_command == CMD_LOAD) begin
      ref_span <= s2_span;
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      overlap[a] = ($signed(s2_span[a].lo) <= $signed(ref_span[a].hi)) &&
                   ($signed(s2_span[a].hi) >= $signed(ref_span[a].lo));
      faces_next[2*a]   = ref_span[a].hi - s2_span[a].lo;
      faces_next[2*a+1] = s2_span[a].hi - ref_span[a].lo;
    end
  end

  assign ctl_next.valid = s2_valid && s2_command == CMD_TEST;
  assign ctl_next.hit   = &overlap;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (advance) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      faces <= faces_next;
    end
  end

  aabb_face_min u_face_min (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .ctl          (ctl),
    .faces        (faces),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ src/aabb_bounds.sv @@
// doubled-scale lower and upper bound of one box axis
`timescale 1ns / 1ps
`default_nettype none
module aabb_bounds import aabb_pkg::*; (
  input  wire logic signed [COORD_W-1:0] pos,
  input  wire logic signed [COORD_W-1:0] off,
  input  wire logic        [LEN_W-1:0]   len,
  output span_t                          span
);

  logic signed [COORD_W:0] centre;
  bound_t                  centre2;
  bound_t                  len_ext;

  assign centre  = {pos[COORD_W-1], pos} + {off[COORD_W-1], off};
  assign centre2 = {{(BOUND_W-COORD_W-2){centre[COORD_W]}}, centre, 1'b0};
  assign len_ext = {{(BOUND_W-LEN_W){1'b0}}, len};

  assign span.lo = centre2 - len_ext;
  assign span.hi = centre2 + len_ext;

endmodule
`default_nettype wire

@@ src/aabb_face_min.sv @@
// least-depth face selection with a pair-minimum register and a result register
`timescale 1ns / 1ps
`default_nettype none
module aabb_face_min import aabb_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire test_ctl_t              ctl,
  input  wire bound_t [FACES-1:0]     faces,
  output logic                        result_valid,
  output result_t                     result
);

  localparam int PAIRS = FACES / 2;

  typedef struct packed {
    bound_t            depth;
    logic [FACE_W-1:0] face;
  } cand_t;

  // first argument wins on a tie
  function automatic cand_t pick_min(input cand_t a, input cand_t b);
    cand_t r;
    r = ($signed(b.depth) < $signed(a.depth)) ? b : a;
    return r;
  endfunction

  cand_t [PAIRS-1:0] pair_next;
  cand_t [PAIRS-1:0] pair;
  test_ctl_t         ctl4;
  cand_t             best01;
  cand_t             best;
  result_t           result_next;

  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      pair_next[p] = pick_min({faces[2*p],   FACE_W'(2*p)},
                              {faces[2*p+1], FACE_W'(2*p+1)});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else if (advance) begin
      ctl4 <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pair <= pair_next;
    end
  end

  assign best01 = pick_min(pair[0], pair[1]);
  assign best   = pick_min(best01, pair[2]);

  always_comb begin
    result_next = '0;
    if (ctl4.hit) begin
      result_next.hit   = 1'b1;
      result_next.face  = best.face;
      result_next.depth = DEPTH_W'(best.depth);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ test/aabb_checker.sv @@
// transaction checker: predicts box overlap results and compares them with the block
`timescale 1ns / 1ps
`default_nettype none
module aabb_checker import aabb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire logic    item_stall,
  input  wire item_t   item,
  input  wire logic    result_valid,
  input  wire logic    result_stall,
  input  wire result_t result,
  output int           errors,
  output int           pending
);

  typedef span_t [AXES-1:0] box_t;

  box_t    anchor_box;
  result_t contact_q[$];
  result_t want;

  assign pending = contact_q.size();

  function automatic span_t axis_span(logic signed [COORD_W-1:0] p,
                                      logic signed [COORD_W-1:0] o,
                                      logic [LEN_W-1:0] l);
    span_t  s;
    longint c;
    c = 2 * (longint'(p) + longint'(o));
    s.lo = bound_t'(c - longint'(l));
    s.hi = bound_t'(c + longint'(l));
    return s;
  endfunction

  function automatic box_t box_bounds(item_t it);
    box_t b;
    b[0] = axis_span(it.pos_x, it.off_x, it.len_x);
    b[1] = axis_span(it.pos_y, it.off_y, it.len_y);
    b[2] = axis_span(it.pos_z, it.off_z, it.len_z);
    return b;
  endfunction

  function automatic result_t predict_contact(box_t a, box_t t);
    result_t res;
    longint  d[FACES];
    longint  alo, ahi, tlo, thi;
    logic    hit;
    int      best;
    res = '0;
    hit = 1'b1;
    for (int k = 0; k < AXES; k++) begin
      alo = longint'($signed(a[k].lo));
      ahi = longint'($signed(a[k].hi));
      tlo = longint'($signed(t[k].lo));
      thi = longint'($signed(t[k].hi));
      if (tlo > ahi || thi < alo) hit = 1'b0;
      d[2*k]   = ahi - tlo;
      d[2*k+1] = thi - alo;
    end
    if (hit) begin
      best = 0;
      for (int f = 1; f < FACES; f++) begin
        if (d[f] < d[best]) best = f;
      end
      res.hit   = 1'b1;
      res.face  = FACE_W'(best);
      res.depth = DEPTH_W'(d[best]);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      anchor_box = '0;
      contact_q.delete();
      errors = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (contact_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got hit %0b face %0d depth %0d",
                   $time, result.hit, result.face, result.depth);
          errors++;
        end else begin
          want = contact_q.pop_front();
          if (result.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, result.hit);
            errors++;
          end
          if (result.face !== want.face) begin
            $display("%0t: face mismatch, expected %0d, got %0d",
                     $time, want.face, result.face);
            errors++;
          end
          if (result.depth !== want.depth) begin
            $display("%0t: depth mismatch, expected %0d, got %0d",
                     $time, want.depth, result.depth);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.command == CMD_LOAD) anchor_box = box_bounds(item);
        else contact_q = {contact_q, predict_contact(anchor_box, box_bounds(item))};
      end
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// testbench top: clock, reset, box stimulus with random gaps and stalls, verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import aabb_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int ONE = 65536;
  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh80000000;
  localparam int LMAX = 32'h7fffffff;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      errors;
  int      pending;

  logic quiet = 1'b0;
  logic stall_on = 1'b0;
  int   stall_left = 0;
  int   mode_left = 0;
  int   stall_pct = 0;

  aabb_overlap_min_penetration dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  aabb_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int jitter(int span);
    if (span == 0) return 0;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic item_t box(logic cmd,
                                logic signed [COORD_W-1:0] px, py, pz,
                                logic signed [COORD_W-1:0] ox, oy, oz,
                                int lx, ly, lz);
    item_t it;
    it.command = cmd;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.off_x = ox; it.off_y = oy; it.off_z = oz;
    it.len_x = LEN_W'(lx); it.len_y = LEN_W'(ly); it.len_z = LEN_W'(lz);
    return it;
  endfunction

  function automatic item_t random_box(logic compact);
    item_t it;
    it.command = CMD_LOAD;
    if (compact) begin
      it = box(CMD_LOAD, jitter(64 * ONE), jitter(64 * ONE), jitter(64 * ONE),
               jitter(8 * ONE), jitter(8 * ONE), jitter(8 * ONE),
               $urandom_range(0, 32 * ONE), $urandom_range(0, 32 * ONE),
               $urandom_range(0, 32 * ONE));
    end else begin
      it.pos_x = $urandom(); it.pos_y = $urandom(); it.pos_z = $urandom();
      it.off_x = $urandom(); it.off_y = $urandom(); it.off_z = $urandom();
      it.len_x = LEN_W'($urandom());
      it.len_y = LEN_W'($urandom());
      it.len_z = LEN_W'($urandom());
    end
    return it;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len(logic [LEN_W-1:0] l);
    case ($urandom_range(0, 5))
      0:       return l;
      1:       return '0;
      2:       return LEN_W'($urandom());
      default: return l >> $urandom_range(0, 4);
    endcase
  endfunction

  function automatic item_t near_box(item_t a, int span);
    item_t t;
    t = a;
    t.command = CMD_TEST;
    t.pos_x = a.pos_x + jitter(span);
    t.pos_y = a.pos_y + jitter(span);
    t.pos_z = a.pos_z + jitter(span);
    t.off_x = a.off_x + jitter(span / 4);
    t.off_y = a.off_y + jitter(span / 4);
    t.off_z = a.off_z + jitter(span / 4);
    t.len_x = pick_len(a.len_x);
    t.len_y = pick_len(a.len_y);
    t.len_z = pick_len(a.len_z);
    return t;
  endfunction

  // entered and left at a falling edge
  task automatic send_box(item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 400);
        stall_pct = 25 * $urandom_range(0, 2);
      end else begin
        mode_left--;
      end
      if (stall_left == 0) begin
        stall_on   = ($urandom_range(0, 99) < stall_pct);
        stall_left = stall_on ? gap_len() : $urandom_range(1, 6);
      end
      stall_left--;
      result_stall <= stall_on;
    end
  end

  initial begin
    item_t anchor;
    item_t noise;
    int    sent;
    int    span;
    logic  compact;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset point box, touching faces, each face, zero lengths, extremes
    quiet = 1'b1;
    send_box(box(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(box(CMD_TEST, ONE, 0, 0, 0, 0, 0, 1, 1, 1));
    send_box(box(CMD_LOAD, 0, 0, 0, 0, 0, 0, 4 * ONE, 4 * ONE, 4 * ONE));
    send_box(box(CMD_TEST, 0, 0, 0, 0, 0, 0, 4 * ONE, 4 * ONE, 4 * ONE));
    send_box(box(CMD_TEST, 3 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, 3 * ONE + 1, 0, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, -3 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, 0, 2 * ONE, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, 0, -2 * ONE, 0, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, 0, 0, -2 * ONE, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
    send_box(box(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(box(CMD_TEST, 0, 0, 9 * ONE, 0, 0, -ONE, ONE, ONE, ONE));
    send_box(box(CMD_TEST, ONE, -ONE, 0, -ONE, ONE, 0, ONE, ONE, ONE));
    send_box(box(CMD_LOAD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, LMAX, LMAX, LMAX));
    send_box(box(CMD_TEST, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, LMAX, LMAX, LMAX));
    send_box(box(CMD_TEST, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, LMAX, LMAX, LMAX));
    send_box(box(CMD_TEST, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0));
    send_box(box(CMD_LOAD, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0));
    send_box(box(CMD_TEST, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, LMAX, LMAX, LMAX));
    send_box(box(CMD_TEST, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0));
    send_box(box(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(box(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(box(CMD_TEST, 0, 0, 0, 0, 0, 0, LMAX, 0, LMAX));

    // random: mostly a reference load followed by nearby test boxes, some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        compact = ($urandom_range(0, 9) < 6);
        anchor  = random_box(compact);
        send_box(anchor);
        sent++;
        case ($urandom_range(0, 2))
          0:       span = 0;
          1:       span = compact ? ONE : (1 << 16);
          default: span = compact ? 16 * ONE : (1 << 28);
        endcase
        repeat ($urandom_range(1, 8)) begin
          send_box(near_box(anchor, span));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          noise = random_box(1'($urandom_range(0, 1)));
          noise.command = 1'($urandom_range(0, 1));
          send_box(noise);
          sent++;
        end
      end
    end
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/aabb_pkg.sv
src/aabb_bounds.sv
src/aabb_face_min.sv
src/aabb_overlap_min_penetration.sv
test/aabb_checker.sv
test/tb.sv
